[rtl/polt_pkg.sv]
// ----------------------------------------------------------------------------
// polt_pkg: shared types and constants for the positional ordered list table
// request codes, status codes, record and result layouts, derived widths
// ----------------------------------------------------------------------------
package polt_pkg;

  // table depth and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths
  localparam int REQ_W    = 3;
  localparam int POS_W    = 6;
  localparam int NAME_W   = 64;
  localparam int AGE_W    = 8;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 7;

  // working width for position / count compares
  localparam int W0_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int W_W      = (W0_W > OCNT_W) ? W0_W : OCNT_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT   = 3'd0,
    REQ_RD_FRONT = 3'd1,
    REQ_RD_BACK  = 3'd2,
    REQ_DELETE   = 3'd3,
    REQ_SEARCH   = 3'd4,
    REQ_CLEAR    = 3'd5
  } req_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } stat_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [AGE_W-1:0]  age;
  } entry_t;

  // table store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    stat_t             status;
    logic [NAME_W-1:0] entry_name;
    logic [AGE_W-1:0]  entry_age;
    logic [POS_W-1:0]  entry_index;
    logic [OCNT_W-1:0] entry_count;
  } result_t;

endpackage

[rtl/polt_in_if.sv]
// ----------------------------------------------------------------------------
// polt_in_if: request channel
// valid/ready handshake carrying one list request
// ----------------------------------------------------------------------------
interface polt_in_if;
  logic                         valid;
  logic                         ready;
  logic [polt_pkg::REQ_W-1:0]   req_type;
  logic [polt_pkg::POS_W-1:0]   position;
  logic [polt_pkg::NAME_W-1:0]  name_key;
  logic [polt_pkg::AGE_W-1:0]   age_value;

  modport source (output valid, req_type, position, name_key, age_value, input ready);
  modport sink   (input valid, req_type, position, name_key, age_value, output ready);
endinterface

[rtl/polt_out_if.sv]
// ----------------------------------------------------------------------------
// polt_out_if: result channel
// valid/ready handshake carrying one list result
// ----------------------------------------------------------------------------
interface polt_out_if;
  logic                         valid;
  logic                         ready;
  logic [polt_pkg::STAT_W-1:0]  status;
  logic [polt_pkg::NAME_W-1:0]  entry_name;
  logic [polt_pkg::AGE_W-1:0]   entry_age;
  logic [polt_pkg::POS_W-1:0]   entry_index;
  logic [polt_pkg::OCNT_W-1:0]  entry_count;

  modport source (output valid, status, entry_name, entry_age, entry_index, entry_count,
                  input ready);
  modport sink   (input valid, status, entry_name, entry_age, entry_index, entry_count,
                  output ready);
endinterface

[rtl/polt_mem.sv]
// ----------------------------------------------------------------------------
// polt_mem: record store
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module polt_mem (
  input  logic                        clk,
  input  polt_pkg::mem_req_t          req,
  output polt_pkg::entry_t            rd_data
);

  polt_pkg::entry_t mem [polt_pkg::CAPACITY];
  polt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/polt_seq.sv]
// ----------------------------------------------------------------------------
// polt_seq: request sequencer
// decodes a request, walks the store one entry a cycle, builds the result
// ----------------------------------------------------------------------------
module polt_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  polt_in_if.sink              in_ch,
  output polt_pkg::mem_req_t   mem_req,
  input  polt_pkg::entry_t     mem_rdata,
  output logic                 res_valid,
  output polt_pkg::result_t    res,
  input  logic                 res_ack
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FINAL = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  polt_pkg::req_e_t                op_r, op_nxt;
  logic [polt_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [polt_pkg::CNT_W-1:0]      rem_r, rem_nxt;
  logic [polt_pkg::ADDR_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic [polt_pkg::ADDR_W-1:0]     last_addr_r, last_addr_nxt;
  logic [polt_pkg::ADDR_W-1:0]     ins_addr_r, ins_addr_nxt;
  logic                            pend_r, pend_nxt;
  logic [polt_pkg::NAME_W-1:0]     key_r, key_nxt;
  logic [polt_pkg::AGE_W-1:0]      age_r, age_nxt;
  polt_pkg::stat_t                 stat_r, stat_nxt;
  logic [polt_pkg::NAME_W-1:0]     name_r, name_nxt;
  logic [polt_pkg::AGE_W-1:0]      oage_r, oage_nxt;
  logic [polt_pkg::POS_W-1:0]      idx_r, idx_nxt;

  logic [polt_pkg::W_W-1:0]        pos_w, cnt_w, ins_w;
  logic                            issue, hit, done;

  assign in_ch.ready = (state_r == S_IDLE);
  assign pos_w = polt_pkg::W_W'(in_ch.position);
  assign cnt_w = polt_pkg::W_W'(count_r);
  assign ins_w = (pos_w > cnt_w) ? cnt_w : pos_w;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    rd_addr_nxt   = rd_addr_r;
    last_addr_nxt = last_addr_r;
    ins_addr_nxt  = ins_addr_r;
    pend_nxt      = pend_r;
    key_nxt       = key_r;
    age_nxt       = age_r;
    stat_nxt      = stat_r;
    name_nxt      = name_r;
    oage_nxt      = oage_r;
    idx_nxt       = idx_r;
    issue         = 1'b0;
    hit           = 1'b0;
    done          = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = last_addr_r;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = rd_addr_r;
    res_valid     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = polt_pkg::req_e_t'(in_ch.req_type);
          key_nxt   = in_ch.name_key;
          age_nxt   = in_ch.age_value;
          stat_nxt  = polt_pkg::ST_OK;
          name_nxt  = '0;
          oage_nxt  = '0;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_RESP;
          case (polt_pkg::req_e_t'(in_ch.req_type))
            polt_pkg::REQ_INSERT: begin
              if (cnt_w >= polt_pkg::W_W'(polt_pkg::CAPACITY)) begin
                stat_nxt = polt_pkg::ST_FULL;
              end else begin
                // shift [ins .. count-1] up by one, walking down from the top
                rem_nxt      = polt_pkg::CNT_W'(cnt_w - ins_w);
                rd_addr_nxt  = polt_pkg::ADDR_W'(cnt_w - polt_pkg::W_W'(1));
                ins_addr_nxt = polt_pkg::ADDR_W'(ins_w);
                count_nxt    = polt_pkg::CNT_W'(cnt_w + polt_pkg::W_W'(1));
                state_nxt    = S_SCAN;
              end
            end
            polt_pkg::REQ_RD_FRONT, polt_pkg::REQ_RD_BACK: begin
              if (pos_w < cnt_w) begin
                rem_nxt     = polt_pkg::CNT_W'(1);
                rd_addr_nxt = (in_ch.req_type == polt_pkg::REQ_RD_FRONT) ?
                              polt_pkg::ADDR_W'(pos_w) :
                              polt_pkg::ADDR_W'(cnt_w - polt_pkg::W_W'(1) - pos_w);
                state_nxt   = S_SCAN;
              end else begin
                stat_nxt = polt_pkg::ST_RANGE;
              end
            end
            polt_pkg::REQ_DELETE: begin
              if (pos_w < cnt_w) begin
                // shift [pos+1 .. count-1] down by one
                rem_nxt     = polt_pkg::CNT_W'(cnt_w - polt_pkg::W_W'(1) - pos_w);
                rd_addr_nxt = polt_pkg::ADDR_W'(pos_w + polt_pkg::W_W'(1));
                count_nxt   = polt_pkg::CNT_W'(cnt_w - polt_pkg::W_W'(1));
                state_nxt   = S_SCAN;
              end else begin
                stat_nxt = polt_pkg::ST_RANGE;
              end
            end
            polt_pkg::REQ_SEARCH: begin
              stat_nxt    = polt_pkg::ST_RANGE;
              rem_nxt     = count_r;
              rd_addr_nxt = '0;
              state_nxt   = S_SCAN;
            end
            polt_pkg::REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              stat_nxt = polt_pkg::ST_RANGE;
            end
          endcase
        end
      end

      S_SCAN: begin
        issue = (rem_r != '0);
        // handle the entry read last cycle
        if (pend_r) begin
          case (op_r)
            polt_pkg::REQ_INSERT: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = last_addr_r + polt_pkg::ADDR_W'(1);
            end
            polt_pkg::REQ_DELETE: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = last_addr_r - polt_pkg::ADDR_W'(1);
            end
            polt_pkg::REQ_SEARCH: begin
              if (mem_rdata.name == key_r) begin
                hit      = 1'b1;
                stat_nxt = polt_pkg::ST_OK;
                name_nxt = mem_rdata.name;
                oage_nxt = mem_rdata.age;
                idx_nxt  = polt_pkg::POS_W'(polt_pkg::W_W'(last_addr_r));
              end
            end
            default: begin
              name_nxt = mem_rdata.name;
              oage_nxt = mem_rdata.age;
            end
          endcase
        end
        done = hit || !issue;
        if (issue) begin
          rem_nxt       = rem_r - polt_pkg::CNT_W'(1);
          last_addr_nxt = rd_addr_r;
          rd_addr_nxt   = (op_r == polt_pkg::REQ_INSERT) ?
                          rd_addr_r - polt_pkg::ADDR_W'(1) :
                          rd_addr_r + polt_pkg::ADDR_W'(1);
        end
        pend_nxt = issue && !done;
        if (done) begin
          state_nxt = (op_r == polt_pkg::REQ_INSERT) ? S_FINAL : S_RESP;
        end
      end

      S_FINAL: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = ins_addr_r;
        mem_req.wdata.name = key_r;
        mem_req.wdata.age  = age_r;
        state_nxt          = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status      = stat_r;
  assign res.entry_name  = name_r;
  assign res.entry_age   = oage_r;
  assign res.entry_index = idx_r;
  assign res.entry_count = polt_pkg::OCNT_W'(cnt_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    rem_r       <= rem_nxt;
    rd_addr_r   <= rd_addr_nxt;
    last_addr_r <= last_addr_nxt;
    ins_addr_r  <= ins_addr_nxt;
    key_r       <= key_nxt;
    age_r       <= age_nxt;
    stat_r      <= stat_nxt;
    name_r      <= name_nxt;
    oage_r      <= oage_nxt;
    idx_r       <= idx_nxt;
  end

endmodule

[rtl/positional_ordered_list_table.sv]
// ----------------------------------------------------------------------------
// positional_ordered_list_table: ordered record list with positional access
// insert, read front/back, delete, search and clear over a 64-entry store
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  in_ch     sink       valid / ready  req_type, position, name_key, age_value
//  out_ch    source     valid / ready  status, entry_name, entry_age,
//                                      entry_index, entry_count
//
// one request at a time; the record store has one read and one write port, and
// walking it one entry a cycle sets the latency
// a read walks one entry; clear, full, out of range and unknown codes walk none;
// delete and search walk k entries (at most count), a search stopping on a hit;
// insert shifts k entries up, then writes the new record
// reset (rst_n low, synchronous) empties the list and drops any result held;
// the store itself is not cleared, only entries below the count are ever read
// a stalled result sits in the output register while the next request runs
//
module positional_ordered_list_table (
  input  logic      clk,
  input  logic      rst_n,
  polt_in_if.sink   in_ch,
  polt_out_if.source out_ch
);

  polt_pkg::mem_req_t  mem_req;
  polt_pkg::entry_t    mem_rdata;
  polt_pkg::result_t   res;
  logic                res_valid;
  logic                res_ack;

  // output register state
  logic                out_valid_r, out_valid_nxt;
  polt_pkg::result_t   out_res_r, out_res_nxt;

  // record store
  polt_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  // request decode and table walk
  polt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ack   (res_ack)
  );

  // the sequencer hands over its result when the output slot is empty or being taken
  assign res_ack = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ack) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      // result taken, nothing new to load
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.entry_name  = out_res_r.entry_name;
  assign out_ch.entry_age   = out_res_r.entry_age;
  assign out_ch.entry_index = out_res_r.entry_index;
  assign out_ch.entry_count = out_res_r.entry_count;

endmodule
